// ===== hw/rtl/ffaa_pkg.sv =====
package ffaa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDLEN,
    ST_CHECK,
    ST_SCAN,
    ST_ASCAN,
    ST_ATAKE,
    ST_FSCAN,
    ST_FDEC,
    ST_SHL,
    ST_SHR,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/ffaa_ram.sv =====
module ffaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/first_fit_arena_allocator.sv =====
// Most requests walk the free table one entry a cycle; some of them then run
// a shift pass of one entry a cycle.
// Throughput: one request at a time; in_stall is high while a request is at work
// and while its result waits to be taken.
// Reset (synchronous, rst_n low): free table holds one block covering the arena,
// result channel empty. Block lengths are not cleared; no clearing pass is run.
module first_fit_arena_allocator #(
  parameter int ARENA_BYTES     = 128,
  parameter int HEADER_BYTES    = 8,
  parameter int MIN_BLOCK_BYTES = 24,
  parameter int MAX_FREE_BLOCKS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_request_size,
  input  logic [6:0] in_payload_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_result_address,
  output logic       out_granted
);

  localparam int AW = $clog2(ARENA_BYTES) + 1;
  localparam int LW = AW + 1;
  localparam int IW = $clog2(MAX_FREE_BLOCKS);
  localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int RW = $clog2(ARENA_BYTES);

  // Each position works on values of AW/LW bits; narrower inputs are zero extended.
  logic [AW-1:0] fs_r   [MAX_FREE_BLOCKS];
  logic [AW-1:0] fs_nxt [MAX_FREE_BLOCKS];
  logic [LW-1:0] fl_r   [MAX_FREE_BLOCKS];
  logic [LW-1:0] fl_nxt [MAX_FREE_BLOCKS];
  logic [CW-1:0] n_r, n_nxt;

  ffaa_pkg::state_t st_r, st_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [8:0]    size_r, size_nxt;
  logic [AW-1:0] h_r, h_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [LW-1:0] need_r, need_nxt;
  logic          ov_r, ov_nxt;
  logic [6:0]    oa_r, oa_nxt;
  logic          og_r, og_nxt;

  logic          we;
  logic [RW-1:0] waddr;
  logic [7:0]    wdata;
  logic [RW-1:0] raddr;
  logic [7:0]    rdata;

  ffaa_ram #(.WIDTH(8), .DEPTH(ARENA_BYTES)) u_len (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [IW-1:0] ii, im1;
  logic [AW-1:0] cur_s, prv_s;
  logic [LW-1:0] cur_l, prv_l;
  logic [LW:0]   prv_end, h_end, cut;
  logic [AW-1:0] pay_ext;

  assign ii      = i_r[IW-1:0];
  assign im1     = IW'(i_r - CW'(1));
  assign cur_s   = fs_r[ii];
  assign cur_l   = fl_r[ii];
  assign prv_s   = fs_r[im1];
  assign prv_l   = fl_r[im1];
  assign prv_end = (LW+1)'(prv_s) + (LW+1)'(prv_l);
  assign h_end   = (LW+1)'(h_r) + (LW+1)'(len_r);
  assign cut     = (LW+1)'(cur_l) - (LW+1)'(need_r);
  assign pay_ext = AW'(in_payload_address);
  assign in_stall = (st_r != ffaa_pkg::ST_IDLE) || ov_r;
  // The header offset is held from acceptance, so the read in ST_RDLEN is stable.
  assign raddr    = RW'(h_r);

  always_comb begin
    logic [LW:0] need9;
    st_nxt = st_r; op_nxt = op_r; size_nxt = size_r; h_nxt = h_r; len_nxt = len_r;
    i_nxt = i_r; k_nxt = k_r; need_nxt = need_r; n_nxt = n_r;
    ov_nxt = ov_r; oa_nxt = oa_r; og_nxt = og_r;
    fs_nxt = fs_r; fl_nxt = fl_r;
    we = 1'b0; waddr = RW'(0); wdata = 8'd0;
    need9 = (LW+1)'(size_r) + (LW+1)'(HEADER_BYTES);
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      ffaa_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt = in_operation;
          size_nxt = 9'(in_request_size);
          h_nxt = pay_ext - AW'(HEADER_BYTES);
          i_nxt = '0;
          if (in_operation == ffaa_pkg::OP_ALLOC) st_nxt = ffaa_pkg::ST_SCAN;
          else if (in_operation == ffaa_pkg::OP_NONE ||
                   pay_ext < AW'(HEADER_BYTES)) begin
            oa_nxt = '0; og_nxt = 1'b0; st_nxt = ffaa_pkg::ST_DONE;
          end else st_nxt = ffaa_pkg::ST_RDLEN;
        end
      end
      ffaa_pkg::ST_RDLEN: st_nxt = ffaa_pkg::ST_CHECK;
      ffaa_pkg::ST_CHECK: begin
        len_nxt = LW'(rdata);
        if (op_r == ffaa_pkg::OP_FREE) begin
          if (rdata == 8'd0 || (LW+1)'(h_r) + (LW+1)'(rdata) > (LW+1)'(ARENA_BYTES)) begin
            oa_nxt = '0; og_nxt = 1'b0; st_nxt = ffaa_pkg::ST_DONE;
          end else st_nxt = ffaa_pkg::ST_FSCAN;
        end else if ((LW+1)'(rdata) >= need9) begin
          oa_nxt = 7'(h_r + AW'(HEADER_BYTES)); og_nxt = 1'b1; st_nxt = ffaa_pkg::ST_DONE;
        end else st_nxt = ffaa_pkg::ST_SCAN;
      end
      ffaa_pkg::ST_SCAN: begin
        need_nxt = (need9 < (LW+1)'(MIN_BLOCK_BYTES)) ? LW'(MIN_BLOCK_BYTES) : LW'(need9);
        st_nxt = ffaa_pkg::ST_ASCAN;
      end
      ffaa_pkg::ST_ASCAN: begin
        if (i_r >= n_r) begin
          oa_nxt = '0; og_nxt = 1'b0; st_nxt = ffaa_pkg::ST_DONE;
        end else if (cur_l >= need_r) st_nxt = ffaa_pkg::ST_ATAKE;
        else i_nxt = i_r + CW'(1);
      end
      ffaa_pkg::ST_ATAKE: begin
        if ((LW+1)'(cur_l) > (LW+1)'(need_r) + (LW+1)'(MIN_BLOCK_BYTES)) begin
          fl_nxt[ii] = LW'(cut);
          we = 1'b1; waddr = RW'((LW+1)'(cur_s) + cut); wdata = 8'(need_r);
          oa_nxt = 7'((LW+1)'(cur_s) + cut + (LW+1)'(HEADER_BYTES));
          og_nxt = 1'b1; st_nxt = ffaa_pkg::ST_DONE;
        end else begin
          we = 1'b1; waddr = RW'(cur_s); wdata = 8'(cur_l);
          oa_nxt = 7'(cur_s + AW'(HEADER_BYTES)); og_nxt = 1'b1;
          k_nxt = i_r; n_nxt = n_r - CW'(1); st_nxt = ffaa_pkg::ST_SHL;
        end
      end
      ffaa_pkg::ST_SHL: begin
        // Close the gap left at k, one entry a cycle.
        if (k_r + CW'(1) < n_r + CW'(1) && k_r + CW'(1) < CW'(MAX_FREE_BLOCKS)) begin
          fs_nxt[k_r[IW-1:0]] = fs_r[IW'(k_r + CW'(1))];
          fl_nxt[k_r[IW-1:0]] = fl_r[IW'(k_r + CW'(1))];
          k_nxt = k_r + CW'(1);
        end else st_nxt = ffaa_pkg::ST_DONE;
      end
      ffaa_pkg::ST_FSCAN: begin
        if (i_r < n_r && !(cur_s > h_r)) i_nxt = i_r + CW'(1);
        else if (i_r != '0 && prv_end > (LW+1)'(h_r)) begin
          oa_nxt = '0; og_nxt = 1'b0; st_nxt = ffaa_pkg::ST_DONE;
        end else if (i_r < n_r && h_end > (LW+1)'(cur_s)) begin
          oa_nxt = '0; og_nxt = 1'b0; st_nxt = ffaa_pkg::ST_DONE;
        end else begin
          oa_nxt = '0; og_nxt = 1'b1; st_nxt = ffaa_pkg::ST_DONE;
          if (i_r != '0 && prv_end == (LW+1)'(h_r)) begin
            if (i_r < n_r && h_end == (LW+1)'(cur_s)) begin
              fl_nxt[im1] = LW'((LW+1)'(prv_l) + (LW+1)'(len_r) + (LW+1)'(cur_l));
              k_nxt = i_r; st_nxt = ffaa_pkg::ST_FDEC;
            end else fl_nxt[im1] = LW'((LW+1)'(prv_l) + (LW+1)'(len_r));
          end else if (i_r < n_r && h_end == (LW+1)'(cur_s)) begin
            fs_nxt[ii] = h_r;
            fl_nxt[ii] = LW'((LW+1)'(cur_l) + (LW+1)'(len_r));
          end else if (n_r >= CW'(MAX_FREE_BLOCKS)) og_nxt = 1'b0;
          else begin
            k_nxt = n_r; n_nxt = n_r + CW'(1); st_nxt = ffaa_pkg::ST_SHR;
          end
        end
      end
      ffaa_pkg::ST_FDEC: begin
        n_nxt = n_r - CW'(1); st_nxt = ffaa_pkg::ST_SHL;
      end
      ffaa_pkg::ST_SHR: begin
        // Open a slot at i by moving entries up, then write the new block.
        if (k_r > i_r) begin
          fs_nxt[k_r[IW-1:0]] = fs_r[IW'(k_r - CW'(1))];
          fl_nxt[k_r[IW-1:0]] = fl_r[IW'(k_r - CW'(1))];
          k_nxt = k_r - CW'(1);
        end else begin
          fs_nxt[ii] = h_r; fl_nxt[ii] = len_r; st_nxt = ffaa_pkg::ST_DONE;
        end
      end
      ffaa_pkg::ST_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; st_nxt = ffaa_pkg::ST_IDLE;
        end
      end
      default: st_nxt = ffaa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ffaa_pkg::ST_IDLE;
      ov_r <= 1'b0;
      n_r  <= CW'(1);
      for (int j = 0; j < MAX_FREE_BLOCKS; j++) begin
        fs_r[j] <= '0;
        fl_r[j] <= '0;
      end
      fl_r[0] <= LW'(ARENA_BYTES);
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      n_r  <= n_nxt;
      fs_r <= fs_nxt;
      fl_r <= fl_nxt;
    end
    op_r <= op_nxt; size_r <= size_nxt; h_r <= h_nxt; len_r <= len_nxt;
    i_r <= i_nxt; k_r <= k_nxt; need_r <= need_nxt;
    oa_r <= oa_nxt; og_r <= og_nxt;
  end

  assign out_valid          = ov_r;
  assign out_result_address = oa_r;
  assign out_granted        = og_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_FREE_BLOCKS)) else $error("free table count out of range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ffaa_pkg::ST_IDLE) |-> in_stall) else $error("request taken while busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_result_address == 7'd0))
    else $error("failed request carries an address");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int ARENA    = 128;
  localparam int HDR      = 8;
  localparam int MIN_BLK  = 24;
  localparam int MAX_FREE = 8;
  localparam int LIMIT    = 600000;

  typedef struct {
    ffaa_pkg::op_t op;
    logic [7:0]    size;
    logic [6:0]    pay;
    bit            hold;
  } request_t;

  typedef struct {
    logic [6:0] addr;
    logic       granted;
  } grant_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = 2'd0;
  logic [7:0] in_request_size = 8'd0;
  logic [6:0] in_payload_address = 7'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_result_address;
  logic       out_granted;

  first_fit_arena_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_payload_address(in_payload_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_address(out_result_address), .out_granted(out_granted)
  );

  always #5 clk = ~clk;

  // Shadow of the arena: free table sorted by start and lengths of handed-out blocks.
  int free_base[MAX_FREE];
  int free_len[MAX_FREE];
  int free_cnt;
  int blk_len[ARENA];
  int handed[$];          // payload offsets whose header length has been written

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int n_total = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int cycles = 0;
  bit quiet_phase = 0;

  function automatic void note_handed(int pay);
    foreach (handed[i]) if (handed[i] == pay) return;
    handed.push_back(pay);
  endfunction

  function automatic bit alloc_block(int size, output int addr);
    int need, i, k, blk;
    need = size + HDR;
    if (need < MIN_BLK) need = MIN_BLK;
    for (i = 0; i < free_cnt; i++) if (free_len[i] >= need) break;
    if (i >= free_cnt) return 0;
    if (free_len[i] > need + MIN_BLK) begin
      free_len[i] -= need;
      blk = free_base[i] + free_len[i];
      blk_len[blk] = need;
    end else begin
      blk = free_base[i];
      blk_len[blk] = free_len[i];
      for (k = i; k + 1 < free_cnt; k++) begin
        free_base[k] = free_base[k + 1];
        free_len[k] = free_len[k + 1];
      end
      free_cnt--;
    end
    addr = blk + HDR;
    note_handed(addr);
    return 1;
  endfunction

  function automatic bit release_block(int h);
    int len, n, p, k;
    bit mprev, mnext;
    len = blk_len[h];
    n = free_cnt;
    if (len == 0 || h + len > ARENA) return 0;
    for (p = 0; p < n; p++) if (free_base[p] > h) break;
    if (p > 0 && free_base[p - 1] + free_len[p - 1] > h) return 0;
    if (p < n && h + len > free_base[p]) return 0;
    mprev = p > 0 && free_base[p - 1] + free_len[p - 1] == h;
    mnext = p < n && h + len == free_base[p];
    if (mprev && mnext) begin
      free_len[p - 1] += len + free_len[p];
      for (k = p; k + 1 < n; k++) begin
        free_base[k] = free_base[k + 1];
        free_len[k] = free_len[k + 1];
      end
      free_cnt--;
    end else if (mprev) begin
      free_len[p - 1] += len;
    end else if (mnext) begin
      free_base[p] = h;
      free_len[p] += len;
    end else begin
      if (n >= MAX_FREE) return 0;
      for (k = n; k > p; k--) begin
        free_base[k] = free_base[k - 1];
        free_len[k] = free_len[k - 1];
      end
      free_base[p] = h;
      free_len[p] = len;
      free_cnt++;
    end
    return 1;
  endfunction

  function automatic grant_t arena_predict(request_t r);
    grant_t g;
    int addr, h;
    g.addr = '0;
    g.granted = 1'b0;
    if (r.op == ffaa_pkg::OP_ALLOC) begin
      if (alloc_block(r.size, addr)) begin
        g.addr = addr[6:0];
        g.granted = 1'b1;
      end
    end else if (r.op != ffaa_pkg::OP_NONE && r.pay >= HDR) begin
      h = r.pay - HDR;
      if (r.op == ffaa_pkg::OP_FREE) begin
        g.granted = release_block(h);
      end else if (blk_len[h] >= r.size + HDR) begin
        g.addr = r.pay;
        g.granted = 1'b1;
      end else if (alloc_block(r.size, addr)) begin
        g.addr = addr[6:0];
        g.granted = 1'b1;
      end
    end
    return g;
  endfunction

  task automatic queue_request(ffaa_pkg::op_t op, int size, int pay, bit hold = 0);
    request_t r;
    r.op = op;
    r.size = size[7:0];
    r.pay = pay[6:0];
    r.hold = hold;
    pending_reqs.push_back(r);
    expected_grants.push_back(arena_predict(r));
    n_total++;
  endtask

  function automatic int pick_handed();
    if (handed.size() == 0) return $urandom_range(0, HDR - 1);
    return handed[$urandom_range(0, handed.size() - 1)];
  endfunction

  function automatic int gap_len();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 25);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on request %0d: %s got %0d expected %0d", n_results, what, got, want);
    n_errors++;
  endtask

  // Request driver.
  int gap = 0;
  always @(posedge clk) begin
    if (in_valid && !in_stall) n_accepted <= n_accepted + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // Hold the request until it is taken.
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() > 0 &&
                 !(pending_reqs[0].hold &&
                   n_results != n_accepted + (in_valid ? 1 : 0))) begin
      request_t r;
      r = pending_reqs.pop_front();
      in_operation <= r.op;
      in_request_size <= r.size;
      in_payload_address <= r.pay;
      in_valid <= 1'b1;
      gap <= gap_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $display("result with no request waiting");
        n_errors++;
      end else begin
        grant_t g;
        g = expected_grants.pop_front();
        if (out_result_address !== g.addr)
          report_mismatch("result_address", out_result_address, g.addr);
        if (out_granted !== g.granted)
          report_mismatch("granted", out_granted, g.granted);
      end
      n_results <= n_results + 1;
    end
    if (!rst_n || quiet_phase) out_stall <= 1'b0;
    else if ($urandom_range(0, 9) < 7) out_stall <= 1'b0;
    else if ($urandom_range(0, 9) < 8) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) if ($urandom_range(0, 199) == 0) quiet_phase <= ~quiet_phase;

  initial begin
    int op_pick, p;
    for (int i = 0; i < MAX_FREE; i++) begin
      free_base[i] = 0;
      free_len[i] = 0;
    end
    for (int i = 0; i < ARENA; i++) blk_len[i] = 0;
    free_len[0] = ARENA;
    free_cnt = 1;

    // Directed part: whole arena, no fit, bad addresses, double free, merges, reallocation.
    queue_request(ffaa_pkg::OP_ALLOC, 255, 0);
    queue_request(ffaa_pkg::OP_ALLOC, 120, 0);
    queue_request(ffaa_pkg::OP_ALLOC, 0, 0);
    queue_request(ffaa_pkg::OP_FREE, 0, 8);
    queue_request(ffaa_pkg::OP_FREE, 0, 8);
    queue_request(ffaa_pkg::OP_NONE, 255, 127);
    queue_request(ffaa_pkg::OP_FREE, 0, 7);
    queue_request(ffaa_pkg::OP_REALLOC, 255, 0);
    queue_request(ffaa_pkg::OP_ALLOC, 0, 0);
    queue_request(ffaa_pkg::OP_ALLOC, 16, 0);
    queue_request(ffaa_pkg::OP_ALLOC, 8, 0);
    queue_request(ffaa_pkg::OP_ALLOC, 0, 0);
    queue_request(ffaa_pkg::OP_REALLOC, 10, pick_handed());
    queue_request(ffaa_pkg::OP_REALLOC, 200, handed[0]);
    queue_request(ffaa_pkg::OP_REALLOC, 40, handed[1], 1);
    foreach (handed[i]) queue_request(ffaa_pkg::OP_FREE, 0, handed[i]);
    queue_request(ffaa_pkg::OP_ALLOC, 119, 0);
    queue_request(ffaa_pkg::OP_FREE, 0, handed[0]);

    // Random part: mostly allocate/free traffic on live blocks, with some noise.
    for (int n = 0; n < 850; n++) begin
      op_pick = $urandom_range(0, 99);
      if (op_pick < 40)
        queue_request(ffaa_pkg::OP_ALLOC,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 40), 0);
      else if (op_pick < 75)
        queue_request(ffaa_pkg::OP_FREE, $urandom_range(0, 255), pick_handed(), n == 400);
      else if (op_pick < 90)
        queue_request(ffaa_pkg::OP_REALLOC, $urandom_range(0, 60), pick_handed());
      else if (op_pick < 95)
        queue_request(ffaa_pkg::OP_NONE, $urandom_range(0, 255), $urandom_range(0, 127));
      else begin
        p = $urandom_range(0, HDR - 1);
        if ($urandom_range(0, 1) != 0)
          queue_request(ffaa_pkg::OP_FREE, $urandom_range(0, 255), p);
        else
          queue_request(ffaa_pkg::OP_REALLOC, $urandom_range(0, 255), p);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && n_accepted == n_total && n_results == n_total);
    repeat (40) @(posedge clk);
    if (n_errors == 0 && expected_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
